FILE: rtl/pgss_pkg.sv
// ----------------------------------------------------------------------------
// pgss_pkg: shared types and constants of the proximity gated sample stream
// Item kinds, host codes, run modes and the item/result records passed
// between the input register, the processing stage and the output register.
// ----------------------------------------------------------------------------
package pgss_pkg;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        KIND_COMMAND = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_ECHO    = 2'd2
    } kind_t;

    // run mode, one-hot
    typedef enum logic [2:0] {
        MODE_WAIT   = 3'b001,
        MODE_MANUAL = 3'b010,
        MODE_DIST   = 3'b100
    } mode_t;

    // host command bytes
    localparam logic [7:0] CODE_MANUAL = 8'h4D;
    localparam logic [7:0] CODE_DIST   = 8'h44;
    localparam logic [7:0] CODE_STOP   = 8'h53;

    localparam logic [5:0] US_PER_CM       = 6'd58;
    localparam logic [2:0] HYSTERESIS_CM   = 3'd5;
    localparam logic [7:0] STOP_MARK       = 8'hFF;
    localparam logic [7:0] FILTER_START    = 8'd128;
    localparam logic [7:0] THRESHOLD_RESET = 8'd10;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned LIMIT_W  = 15;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  command_code;
        logic [7:0]  sample_value;
        logic [15:0] echo_time_us;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       is_stop;
    } result_t;

endpackage

FILE: rtl/pgss_in_reg.sv
// ----------------------------------------------------------------------------
// pgss_in_reg: input register
// Captures one item from the slave channel; releases it when the processing
// stage takes it.
// ----------------------------------------------------------------------------
module pgss_in_reg
    import pgss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              take,      // processing stage consumes the held item
    output logic              held_valid,
    output item_t             held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind         <= kind_t'(s_tuser);
            item_reg.command_code <= s_tdata[7:0];
            item_reg.sample_value <= s_tdata[15:8];
            item_reg.echo_time_us <= s_tdata[31:16];
        end
    end

endmodule

FILE: rtl/pgss_proc.sv
// ----------------------------------------------------------------------------
// pgss_proc: mode, recording gate and smoothing filter
// Updates run mode, recording flag and filter history for each item taken,
// and forms the result, if any, for the output register.
// ----------------------------------------------------------------------------
module pgss_proc
    import pgss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,          // held item is processed this cycle
    input  item_t      item,
    input  logic [7:0] threshold,
    output result_t    res
);

    mode_t      mode_reg, mode_next;
    logic       recording_reg, recording_next;
    logic [7:0] last_sample_reg, last_sample_next;

    logic [LIMIT_W-1:0] start_lim;   // echo below this: cm <= threshold
    logic [LIMIT_W-1:0] stop_lim;    // echo at or above: cm > threshold + 5
    logic [8:0]         sum;
    logic [7:0]         avg;
    logic               pass;

    assign start_lim = (LIMIT_W'(threshold) + LIMIT_W'(1)) * LIMIT_W'(US_PER_CM);
    assign stop_lim  = (LIMIT_W'(threshold) + LIMIT_W'(HYSTERESIS_CM) + LIMIT_W'(1))
                       * LIMIT_W'(US_PER_CM);

    assign sum  = {1'b0, last_sample_reg} + {1'b0, item.sample_value};
    assign avg  = sum[8:1];
    assign pass = (mode_reg == MODE_MANUAL) || ((mode_reg == MODE_DIST) && recording_reg);

    always_comb
    begin
        mode_next        = mode_reg;
        recording_next   = recording_reg;
        last_sample_next = last_sample_reg;
        res.valid        = 1'b0;
        res.out_byte     = avg;
        res.is_stop      = 1'b0;
        if (go)
        begin
            unique case (item.kind)
                KIND_COMMAND:
                begin
                    priority if (item.command_code == CODE_MANUAL)
                    begin
                        mode_next        = MODE_MANUAL;
                        recording_next   = 1'b0;
                        last_sample_next = FILTER_START;
                    end
                    else if (item.command_code == CODE_DIST)
                    begin
                        mode_next        = MODE_DIST;
                        recording_next   = 1'b0;
                        last_sample_next = FILTER_START;
                    end
                    else if (item.command_code == CODE_STOP && mode_reg != MODE_WAIT)
                    begin
                        mode_next        = MODE_WAIT;
                        recording_next   = 1'b0;
                        last_sample_next = FILTER_START;
                    end
                    else
                    begin
                        mode_next = mode_reg;
                    end
                end
                KIND_SAMPLE:
                begin
                    if (pass)
                    begin
                        res.valid        = 1'b1;
                        last_sample_next = item.sample_value;
                    end
                end
                KIND_ECHO:
                begin
                    if (mode_reg == MODE_DIST)
                    begin
                        priority if (!recording_reg && (item.echo_time_us < 16'(start_lim)))
                        begin
                            recording_next   = 1'b1;
                            last_sample_next = FILTER_START;
                        end
                        else if (recording_reg && (item.echo_time_us >= 16'(stop_lim)))
                        begin
                            recording_next = 1'b0;
                            res.valid      = 1'b1;
                            res.out_byte   = STOP_MARK;
                            res.is_stop    = 1'b1;
                        end
                        else
                        begin
                            recording_next = recording_reg;
                        end
                    end
                end
                default:
                begin
                    mode_next = mode_reg;   // unused kind: no effect
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_WAIT;
            recording_reg   <= 1'b0;
            last_sample_reg <= FILTER_START;
        end
        else
        begin
            mode_reg        <= mode_next;
            recording_reg   <= recording_next;
            last_sample_reg <= last_sample_next;
        end
    end

    // a stop marker only ends a running recording
    a_stop_ends_rec: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.is_stop |-> recording_reg && !recording_next)
        else $error("stop marker without an active recording");

    // nothing is forwarded while waiting
    a_wait_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_WAIT |-> !res.valid)
        else $error("result produced while waiting");

    // only commands change the mode
    a_mode_by_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        go && item.kind != KIND_COMMAND |=> mode_reg == $past(mode_reg))
        else $error("mode changed by a non-command item");

    // a forwarded sample becomes the filter history
    a_filter_hist: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.is_stop |=> last_sample_reg == $past(item.sample_value))
        else $error("filter history not updated");

endmodule

FILE: rtl/pgss_out_reg.sv
// ----------------------------------------------------------------------------
// pgss_out_reg: result register
// Holds one result for the master channel; free again once it is taken.
// ----------------------------------------------------------------------------
module pgss_out_reg
    import pgss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,       // processing stage advances this cycle
    input  result_t    res,
    output logic       free,       // room for a result this cycle
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [0:0] m_tuser
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       stop_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = stop_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            byte_reg <= res.out_byte;
            stop_reg <= res.is_stop;
        end
    end

endmodule

FILE: rtl/proximity_gated_sample_stream.sv
// ----------------------------------------------------------------------------
// proximity_gated_sample_stream: distance gated audio byte stream
// Host commands select manual or distance mode; echo times gate recording,
// samples are smoothed by a two-tap average and forwarded.
// ----------------------------------------------------------------------------
// Usage
//  - Slave channel: one item per handshake. s_tuser gives the kind (host
//    command, audio sample, echo time); s_tdata carries code, sample, echo.
//  - Master channel: zero or one item per input item, a smoothed sample or
//    the 0xFF stop marker, flagged in m_tuser, when a recording ends.
//  - cfg_wen/cfg_wdata write the detection threshold in cm; write only while
//    the block is idle. Reset value 10.
//  - Throughput: one item per cycle while the receiver takes results. Each
//    item passes the input register, then the result register, before
//    m_tvalid rises.
//  - The distance compare uses (threshold+1)*58 and (threshold+6)*58 limits, no divider.
//  - Reset: waiting mode, not recording, filter history 128, no item held.
//  - Receiver stall: the result register holds its item; one further input
//    item is taken into the input register, then s_tready drops until the
//    result is taken.
// ----------------------------------------------------------------------------
module proximity_gated_sample_stream
    import pgss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [7:0] command_code, [15:8] sample_value,
                                         // [31:16] echo_time_us
    input  logic [1:0]        s_tuser,   // [1:0] cmd (item kind)
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic [0:0]        m_tuser,   // [0] is_stop
    // threshold register
    input  logic              cfg_wen,
    input  logic [7:0]        cfg_wdata
);

    logic       threshold_reg;
    logic [7:0] thr_reg;
    logic       held_valid;
    item_t      held_item;
    logic       out_free;
    logic       proc_go;
    result_t    res;

    // held item advances when the result register has room
    assign proc_go = held_valid && out_free;

    // threshold register: written directly, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            threshold_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            thr_reg       <= cfg_wdata;
            threshold_reg <= 1'b1;
        end
    end

    pgss_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (proc_go),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    pgss_proc u_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (proc_go),
        .item      (held_item),
        .threshold (thr_reg),
        .res       (res)
    );

    pgss_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (proc_go),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // an item is only processed from a full input register into free space
    a_go_ok: assert property (@(posedge clk) disable iff (!rst_n)
        proc_go |-> held_valid && (!m_tvalid || m_tready))
        else $error("item processed without room for its result");

    // a written threshold takes effect on the next edge
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> thr_reg == $past(cfg_wdata) && threshold_reg)
        else $error("threshold write lost");

    // an accepted input is always held in the next cycle, ready for processing
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> held_valid)
        else $error("accepted item not held");

endmodule
